>>> rtl/byte_keyed_table_search_unit_macros.svh
// assertion macros for the byte keyed table search unit
// each macro samples on clk and is disabled while rst_n is low
`ifndef BYTE_KEYED_TABLE_SEARCH_UNIT_MACROS_SVH
`define BYTE_KEYED_TABLE_SEARCH_UNIT_MACROS_SVH
`ifndef SYNTH
// condition in this cycle implies consequence in this cycle
`define BKTS_ASSERT_NOW(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("bkts assertion failed");
// condition in this cycle implies consequence in the next cycle
`define BKTS_ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("bkts assertion failed");
`else
`define BKTS_ASSERT_NOW(lbl, cond, cons)
`define BKTS_ASSERT_NEXT(lbl, cond, cons)
`endif
`endif

>>> rtl/bkts_pkg.sv
`timescale 1ns / 1ps
package bkts_pkg;

  // layout register code for zero-terminated 8-byte entries
  localparam logic [7:0] LAYOUT_TERM  = 8'hff;
  // layout register code for an empty table
  localparam logic [7:0] LAYOUT_EMPTY = 8'h00;

  // operation codes of an input beat
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // value word fetch: four byte reads, last capture at count four
  localparam logic [2:0] VAL_LAST = 3'd4;

  typedef struct packed {
    logic        operation;
    logic [10:0] address;
    logic [7:0]  write_byte;
    logic [7:0]  key;
  } bkts_in_t;

  typedef struct packed {
    logic        found;
    logic [31:0] value;
  } bkts_out_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_VAL  = 3'b100
  } bkts_state_t;

endpackage

>>> rtl/byte_keyed_table_search_unit.sv
`timescale 1ns / 1ps
// Byte keyed table search unit. A beat is taken when start is high and busy is
// low. A write beat stores one byte in table memory and gives no result; busy
// stays low. A lookup beat walks the table through the single byte read port
// of the table memory, one entry per cycle: a miss is strobed on out_valid once
// the scan stops, a hit once the value word has been fetched byte by byte, and
// an empty table answers in the next cycle. At most 254 entries are scanned in
// the counted layout, up to TABLE_BYTES/8 in the zero-terminated layout. The
// result is shown for exactly one cycle and cannot be held off; the next beat
// may be taken in that same cycle. Table memory has no reset and needs no
// clearing pass: reading bytes never written gives undefined values.
// Write the layout register only while busy is low and no result is pending.
`include "byte_keyed_table_search_unit_macros.svh"
module byte_keyed_table_search_unit
  import bkts_pkg::*;
#(
  parameter int TABLE_BYTES = 2048
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  bkts_in_t  in_data,
  output logic      out_valid,
  output bkts_out_t out_data,
  input  logic      cfg_we,
  input  logic [7:0] cfg_wdata
);

  localparam int AW = $clog2(TABLE_BYTES);

  logic [7:0]    layout_r;
  logic          accept;
  logic          wr_en;
  logic          go;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  // layout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_r <= LAYOUT_EMPTY;
    end else if (cfg_we) begin
      layout_r <= cfg_wdata;
    end
  end

  // beat decode; writes beyond the memory are dropped
  assign accept = start && !busy;
  assign wr_en  = accept && (in_data.operation == OP_WRITE)
               && (32'(in_data.address) < 32'(TABLE_BYTES));
  assign go     = accept && (in_data.operation == OP_LOOKUP);

  // table memory; writes only land while the walk is idle
  bkts_mem #(
    .DEPTH (TABLE_BYTES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_data.address)),
    .wr_data (in_data.write_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // search sequencer
  bkts_walk #(
    .TABLE_BYTES (TABLE_BYTES),
    .AW          (AW)
  ) u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .key       (in_data.key),
    .layout    (layout_r),
    .busy      (busy),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res_valid (out_valid),
    .res       (out_data)
  );

  // checks
  `BKTS_ASSERT_NOW(a_miss_zero, out_valid && !out_data.found, out_data.value == 32'h0)
  `BKTS_ASSERT_NOW(a_strobe_idle, out_valid, !busy)
  `BKTS_ASSERT_NEXT(a_empty_fast, go && (layout_r == LAYOUT_EMPTY), out_valid && !out_data.found)
  `BKTS_ASSERT_NEXT(a_write_silent, accept && (in_data.operation == OP_WRITE), !out_valid && !busy)

endmodule

>>> rtl/bkts_mem.sv
`timescale 1ns / 1ps
module bkts_mem
  import bkts_pkg::*;
#(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem_r [DEPTH];
  logic [7:0] rd_data_r;

  // byte write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // byte read port, data registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/bkts_walk.sv
`timescale 1ns / 1ps
module bkts_walk
  import bkts_pkg::*;
#(
  parameter int TABLE_BYTES = 2048,
  parameter int AW          = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [7:0]    key,
  input  logic [7:0]    layout,
  output logic          busy,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  input  logic [7:0]    rd_data,
  output logic          res_valid,
  output bkts_out_t     res
);

  // entry index must reach one past the last whole 8-byte entry
  localparam int MAX_ENT = TABLE_BYTES / 8;
  localparam int EW      = $clog2(MAX_ENT + 1);
  localparam int XW      = EW + 3;

  bkts_state_t     state_r, state_nxt;
  logic [EW-1:0]   idx_r, idx_nxt;
  logic [7:0]      key_r, key_nxt;
  logic [AW-1:0]   vbase_r, vbase_nxt;
  logic [2:0]      bcnt_r, bcnt_nxt;
  logic [31:0]     val_r, val_nxt;
  logic            res_valid_r, res_valid_nxt;
  bkts_out_t       res_r, res_nxt;

  logic            term;
  logic [EW-1:0]   rd_idx;
  logic [EW-1:0]   cur_idx;
  logic [XW-1:0]   key_xaddr;
  logic [XW-1:0]   val_xaddr;
  logic            key_in_range;
  logic            hit;
  logic            stop_miss;
  logic [31:0]     val_shift;

  assign term = (layout == LAYOUT_TERM);

  // key byte address of the entry being issued
  assign rd_idx    = (state_r == ST_IDLE) ? '0 : idx_r;
  assign key_xaddr = term ? {rd_idx, 3'b000}
                          : XW'({layout, 2'b00}) + XW'(rd_idx);
  assign key_in_range = (key_xaddr < XW'(TABLE_BYTES));

  // entry whose key byte is on rd_data during the scan
  assign cur_idx   = idx_r - EW'(1);
  assign val_xaddr = term ? XW'({cur_idx, 3'b100}) : XW'({cur_idx, 2'b00});

  // key compare: a zero key ends the terminated layout and never matches
  assign hit = term ? ((rd_data != 8'h00) && (rd_data == key_r)) : (rd_data == key_r);
  assign stop_miss = term ? ((rd_data == 8'h00) || (idx_r >= EW'(MAX_ENT)))
                          : (idx_r == EW'(layout));

  assign val_shift = {rd_data, val_r[31:8]};

  // memory read request
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = AW'(key_xaddr);
    unique case (state_r)
      ST_IDLE: rd_en = go && (layout != LAYOUT_EMPTY);
      ST_SCAN: rd_en = key_in_range;
      ST_VAL: begin
        rd_en   = (bcnt_r != VAL_LAST);
        rd_addr = vbase_r + AW'(bcnt_r[1:0]);
      end
      default: rd_en = 1'b0;
    endcase
  end

  // walk sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    key_nxt       = key_r;
    vbase_nxt     = vbase_r;
    bcnt_nxt      = bcnt_r;
    val_nxt       = val_r;
    res_valid_nxt = 1'b0;
    res_nxt       = res_r;
    unique case (state_r)
      ST_IDLE: begin
        if (go) begin
          key_nxt = key;
          if (layout == LAYOUT_EMPTY) begin
            res_valid_nxt = 1'b1;
            res_nxt       = '{found: 1'b0, value: 32'h0};
          end else begin
            idx_nxt   = EW'(1);
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          vbase_nxt = AW'(val_xaddr);
          bcnt_nxt  = '0;
          state_nxt = ST_VAL;
        end else if (stop_miss) begin
          res_valid_nxt = 1'b1;
          res_nxt       = '{found: 1'b0, value: 32'h0};
          state_nxt     = ST_IDLE;
        end else begin
          idx_nxt = idx_r + EW'(1);
        end
      end
      ST_VAL: begin
        bcnt_nxt = bcnt_r + 3'd1;
        if (bcnt_r != 3'd0) begin
          val_nxt = val_shift;
        end
        if (bcnt_r == VAL_LAST) begin
          res_valid_nxt = 1'b1;
          res_nxt       = '{found: 1'b1, value: val_shift};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    key_r   <= key_nxt;
    vbase_r <= vbase_nxt;
    bcnt_r  <= bcnt_nxt;
    val_r   <= val_nxt;
    res_r   <= res_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import bkts_pkg::*;

  localparam int TABLE_BYTES  = 2048;
  localparam int ENTRY_BYTES  = 8;
  localparam int WORD_BYTES   = 4;
  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 300;
  localparam int PHASES       = 8;
  localparam int PHASE_BEATS  = 48;
  localparam int TERM_MAX_LEN = 12;
  localparam int FILL_MAX_N   = 24;
  localparam int BIG_N        = 254;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    bkts_in_t   beat;
    logic [7:0] cfg_val;
    bit         typed;
    bkts_out_t  want;
  } dir_row_t;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  bkts_in_t   in_data;
  logic       out_valid;
  bkts_out_t  out_data;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  // shadow of the table memory and the layout register
  logic [7:0] tbl_bytes [TABLE_BYTES];
  logic [7:0] layout_reg;

  bkts_out_t  lookup_answers [$];
  dir_row_t   dir_rows [$];

  int idle_pct;
  int n_items;
  int n_writes;
  int n_lookups;
  int n_hits;
  int n_cfg;
  int n_errors;
  int quiet_cycles;

  byte_keyed_table_search_unit #(
    .TABLE_BYTES(TABLE_BYTES)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic [7:0] byte_at(int unsigned addr);
    if (addr >= TABLE_BYTES) return 8'h00;
    return tbl_bytes[addr];
  endfunction

  function automatic logic [31:0] word_at(int unsigned addr);
    return {byte_at(addr + 3), byte_at(addr + 2), byte_at(addr + 1), byte_at(addr)};
  endfunction

  // first matching entry under the current layout
  function automatic bkts_out_t search_table(logic [7:0] key);
    bkts_out_t   res;
    bit          done;
    int unsigned i;
    int unsigned n;
    res  = '0;
    done = 1'b0;
    if (layout_reg == LAYOUT_TERM) begin
      for (i = 0; !done && (i + 1) * ENTRY_BYTES <= TABLE_BYTES; i++) begin
        if (byte_at(i * ENTRY_BYTES) == 8'h00) begin
          done = 1'b1;
        end else if (byte_at(i * ENTRY_BYTES) == key) begin
          res.found = 1'b1;
          res.value = word_at(i * ENTRY_BYTES + WORD_BYTES);
          done      = 1'b1;
        end
      end
    end else begin
      n = layout_reg;
      for (i = 0; !done && i < n; i++) begin
        if (byte_at(n * WORD_BYTES + i) == key) begin
          res.found = 1'b1;
          res.value = word_at(i * WORD_BYTES);
          done      = 1'b1;
        end
      end
    end
    return res;
  endfunction

  function automatic bkts_in_t rand_beat(logic op);
    bkts_in_t b;
    b.operation  = op;
    b.address    = 11'($urandom_range(0, TABLE_BYTES - 1));
    b.write_byte = 8'($urandom_range(0, 255));
    b.key        = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // directed table builders
  function automatic dir_row_t blank_row();
    dir_row_t r;
    r.kind    = ROW_BEAT;
    r.beat    = '0;
    r.cfg_val = 8'h00;
    r.typed   = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  function automatic void add_cfg(logic [7:0] v);
    dir_row_t r;
    r         = blank_row();
    r.kind    = ROW_CFG;
    r.cfg_val = v;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_write(logic [10:0] addr, logic [7:0] d);
    dir_row_t r;
    r                 = blank_row();
    r.kind            = ROW_BEAT;
    r.beat.operation  = OP_WRITE;
    r.beat.address    = addr;
    r.beat.write_byte = d;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_lookup(logic [7:0] key, bit typed, logic found,
                                     logic [31:0] value);
    dir_row_t r;
    r                = blank_row();
    r.kind           = ROW_BEAT;
    r.beat.operation = OP_LOOKUP;
    r.beat.key       = key;
    r.typed          = typed;
    r.want.found     = found;
    r.want.value     = value;
    dir_rows.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
    n_errors++;
  endtask

  // drive one beat, with an optional idle gap in front
  task automatic send_beat(input bkts_in_t b, input bit typed, input bkts_out_t want);
    int gap;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (busy);
    n_items++;
    if (b.operation == OP_WRITE) begin
      tbl_bytes[b.address] = b.write_byte;
      n_writes++;
    end else begin
      lookup_answers.push_back(typed ? want : search_table(b.key));
      n_lookups++;
    end
  endtask

  // layout register write, only once the unit is idle
  task automatic write_layout(input logic [7:0] v);
    @(negedge clk);
    start <= 1'b0;
    while (lookup_answers.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we     <= 1'b0;
    layout_reg  = v;
    n_cfg++;
  endtask

  // result check
  always @(posedge clk) begin
    bkts_out_t want;
    if (rst_n && out_valid) begin
      if (lookup_answers.size() == 0) begin
        report_mismatch("result beat with no lookup pending", out_data.value, 32'h0);
      end else begin
        want = lookup_answers.pop_front();
        if (out_data.found !== want.found)
          report_mismatch("found", {31'h0, out_data.found}, {31'h0, want.found});
        if (out_data.value !== want.value)
          report_mismatch("value", out_data.value, want.value);
      end
      if (out_data.found === 1'b1) n_hits++;
    end
  end

  // watchdog on cycles with no beat in either direction
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    bkts_in_t    b;
    dir_row_t    row;
    logic [7:0]  lay;
    logic [7:0]  k;
    int          p;
    int          i;
    int          a;
    int          r;
    int          term_len;
    int          span;
    int          n_eff;
    int          phase_end;
    int unsigned key_addr;
    int unsigned val_addr;

    rst_n        = 1'b0;
    start        = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = 8'h00;
    layout_reg   = LAYOUT_EMPTY;
    idle_pct     = 0;
    n_items      = 0;
    n_writes     = 0;
    n_lookups    = 0;
    n_hits       = 0;
    n_cfg        = 0;
    n_errors     = 0;
    quiet_cycles = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // key byte of every 8-byte entry, never 0 or 255
    for (a = 0; a < TABLE_BYTES / ENTRY_BYTES; a++) begin
      b            = rand_beat(OP_WRITE);
      b.address    = 11'(a * ENTRY_BYTES);
      b.write_byte = 8'($urandom_range(1, 254));
      send_beat(b, 1'b0, '0);
    end
    // value words of the first entries and the rest of the first word
    for (a = 1; a < TERM_MAX_LEN * ENTRY_BYTES; a++) begin
      if (a % ENTRY_BYTES >= WORD_BYTES || a < WORD_BYTES) begin
        b         = rand_beat(OP_WRITE);
        b.address = 11'(a);
        send_beat(b, 1'b0, '0);
      end
    end

    // empty table after reset
    add_lookup(8'h00, 1'b1, 1'b0, 32'h0);
    add_lookup(8'hff, 1'b1, 1'b0, 32'h0);
    // terminated layout: one entry then a zero key
    add_cfg(LAYOUT_TERM);
    add_write(11'd0, 8'h5a);
    add_write(11'd4, 8'hff);
    add_write(11'd5, 8'hff);
    add_write(11'd6, 8'hff);
    add_write(11'd7, 8'hff);
    add_write(11'd8, 8'h00);
    add_lookup(8'h5a, 1'b1, 1'b1, 32'hffff_ffff);
    add_lookup(8'h00, 1'b1, 1'b0, 32'h0);
    add_lookup(8'h11, 1'b1, 1'b0, 32'h0);
    // no terminator left: walk runs off the end of memory
    add_write(11'd8, 8'h77);
    add_lookup(8'hff, 1'b1, 1'b0, 32'h0);
    add_write(11'h7ff, 8'h00);
    add_write(11'h7fe, 8'hff);
    // counted layout, smallest and largest counts
    add_cfg(8'd1);
    add_lookup(8'hff, 1'b0, 1'b0, 32'h0);
    add_lookup(8'h00, 1'b0, 1'b0, 32'h0);
    // key area of the largest counted table, all zero keys
    for (a = BIG_N * WORD_BYTES; a < BIG_N * (WORD_BYTES + 1); a++) begin
      add_write(11'(a), 8'h00);
    end
    add_cfg(8'(BIG_N));
    add_lookup(8'h77, 1'b0, 1'b0, 32'h0);
    add_lookup(8'h00, 1'b0, 1'b0, 32'h0);
    add_cfg(LAYOUT_EMPTY);
    add_lookup(8'h5a, 1'b1, 1'b0, 32'h0);

    foreach (dir_rows[j]) begin
      row = dir_rows[j];
      if (row.kind == ROW_CFG) write_layout(row.cfg_val);
      else send_beat(row.beat, row.typed, row.want);
    end

    // random phases, each with its own layout and idle pattern
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0, 5:    lay = LAYOUT_TERM;
        1:       lay = 8'd1;
        2, 7:    lay = 8'(BIG_N);
        3:       lay = LAYOUT_EMPTY;
        default: lay = 8'($urandom_range(2, FILL_MAX_N));
      endcase
      write_layout(lay);
      case (p % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 74;
        default: idle_pct = 12;
      endcase

      term_len = 0;
      n_eff    = (lay == LAYOUT_EMPTY) ? 8 : lay;
      if (lay == LAYOUT_TERM) begin
        term_len     = $urandom_range(1, TERM_MAX_LEN);
        b            = rand_beat(OP_WRITE);
        b.address    = 11'(term_len * ENTRY_BYTES);
        b.write_byte = 8'h00;
        send_beat(b, 1'b0, '0);
        span = term_len;
      end else begin
        span = n_eff;
        // small counted tables get fresh values and keys
        if (lay != LAYOUT_EMPTY && lay != 8'(BIG_N)) begin
          for (a = 0; a < n_eff * (WORD_BYTES + 1); a++) begin
            b         = rand_beat(OP_WRITE);
            b.address = 11'(a);
            send_beat(b, 1'b0, '0);
          end
        end
      end

      phase_end = n_items + PHASE_BEATS;
      while (n_items < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          // well-formed entry: key, value word, then a lookup of that key
          i = $urandom_range(0, span - 1);
          if (lay == LAYOUT_TERM) begin
            k        = 8'($urandom_range(1, 255));
            key_addr = i * ENTRY_BYTES;
            val_addr = i * ENTRY_BYTES + WORD_BYTES;
          end else begin
            k        = 8'($urandom_range(0, 255));
            key_addr = n_eff * WORD_BYTES + i;
            val_addr = i * WORD_BYTES;
          end
          b            = rand_beat(OP_WRITE);
          b.address    = 11'(key_addr);
          b.write_byte = k;
          send_beat(b, 1'b0, '0);
          for (a = 0; a < WORD_BYTES; a++) begin
            b         = rand_beat(OP_WRITE);
            b.address = 11'(val_addr + a);
            send_beat(b, 1'b0, '0);
          end
          b     = rand_beat(OP_LOOKUP);
          b.key = k;
          send_beat(b, 1'b0, '0);
        end else if (r < 85) begin
          send_beat(rand_beat(OP_LOOKUP), 1'b0, '0);
        end else begin
          // random value byte of an entry in use
          b = rand_beat(OP_WRITE);
          if (lay == LAYOUT_TERM) begin
            i         = $urandom_range(0, span - 1);
            a         = $urandom_range(0, WORD_BYTES - 1);
            b.address = 11'(i * ENTRY_BYTES + WORD_BYTES + a);
          end else begin
            b.address = 11'($urandom_range(0, span * WORD_BYTES - 1));
          end
          send_beat(b, 1'b0, '0);
        end
      end
    end

    // drain
    @(negedge clk);
    start <= 1'b0;
    while (lookup_answers.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d write beats and %0d lookups (%0d hits) over %0d layout settings",
             n_writes, n_lookups, n_hits, n_cfg);
    $display("layouts: empty, terminated, counted 1, 254 and random; %0d mismatches",
             n_errors);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
